>>> rtl/cdu_pkg.sv
`timescale 1ns / 1ps

package cdu_pkg;

	// action codes
	localparam logic [1:0] ACT_NEXT     = 2'd0;
	localparam logic [1:0] ACT_PREV     = 2'd1;
	localparam logic [1:0] ACT_VALIDATE = 2'd2;
	localparam logic [1:0] ACT_DAYNUM   = 2'd3;

	localparam int unsigned MAX_YEAR = 9999;

	// y / 100 as (y * RECIP100) >> RECIP_SHIFT, exact for y below 2**14
	localparam logic [12:0] RECIP100    = 13'd5243;
	localparam int unsigned RECIP_SHIFT = 19;

	localparam logic [8:0] DAYS_IN_YEAR = 9'd365;

	typedef struct packed {
		logic [4:0]  day;
		logic [3:0]  month;
		logic [13:0] year;
		logic        ok;
		logic        leap;
		logic [21:0] num;
	} cdu_result_t;

	// length of month m, m in 1..12
	function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
		logic [4:0] n;
		case (m)
			4'd2:    n = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
			default: n = 5'd31;
		endcase
		return n;
	endfunction

	// days in a common year before the first of month m
	function automatic logic [8:0] days_before(input logic [3:0] m);
		logic [8:0] n;
		case (m)
			4'd2:    n = 9'd31;
			4'd3:    n = 9'd59;
			4'd4:    n = 9'd90;
			4'd5:    n = 9'd120;
			4'd6:    n = 9'd151;
			4'd7:    n = 9'd181;
			4'd8:    n = 9'd212;
			4'd9:    n = 9'd243;
			4'd10:   n = 9'd273;
			4'd11:   n = 9'd304;
			4'd12:   n = 9'd334;
			default: n = 9'd0;
		endcase
		return n;
	endfunction

endpackage

>>> rtl/cdu_if.sv
`timescale 1ns / 1ps

// request channel: action and date
interface cdu_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [6:0]  in_day;
	logic [6:0]  in_month;
	logic [13:0] in_year;

	modport source (output valid, action, in_day, in_month, in_year, input ready);
	modport sink   (input valid, action, in_day, in_month, in_year, output ready);
endinterface

// response channel: resulting date and flags
interface cdu_rsp_if;
	logic        valid;
	logic        ready;
	logic [4:0]  out_day;
	logic [3:0]  out_month;
	logic [13:0] out_year;
	logic        date_ok;
	logic        leap_year;
	logic [21:0] day_number;

	modport source (output valid, out_day, out_month, out_year, date_ok, leap_year,
		day_number, input ready);
	modport sink   (input valid, out_day, out_month, out_year, date_ok, leap_year,
		day_number, output ready);
endinterface

>>> rtl/cdu_leap.sv
`timescale 1ns / 1ps

module cdu_leap
	import cdu_pkg::*;
(
	input  logic [13:0] year,
	output logic [7:0]  cent,
	output logic        leap
);

	logic [26:0] prod;
	logic [13:0] rem;
	logic [13:0] cent_x100;

	// reciprocal multiply for year / 100
	assign prod      = {13'd0, year} * {14'd0, RECIP100};
	assign cent      = prod[RECIP_SHIFT +: 8];
	assign cent_x100 = 14'({6'd0, cent} * 14'd100);
	assign rem       = year - cent_x100;

	// divisible by 4, and not by 100 unless by 400
	assign leap = (year[1:0] == 2'd0) && ((rem != 14'd0) || (cent[1:0] == 2'd0));

endmodule

>>> rtl/cdu_core.sv
`timescale 1ns / 1ps

module cdu_core
	import cdu_pkg::*;
(
	input  logic [1:0]  action,
	input  logic [6:0]  in_day,
	input  logic [6:0]  in_month,
	input  logic [13:0] in_year,
	output cdu_result_t res
);

	logic [13:0] y_prev, y_next;
	logic [7:0]  cent_cur, cent_prev, cent_next;
	logic        leap_cur, leap_prev, leap_next;
	logic [3:0]  mi;
	logic [4:0]  di;
	logic [4:0]  dim_cur, dim_before;
	logic        valid;
	logic [21:0] n_years, n_days;

	assign y_prev = in_year - 14'd1;
	assign y_next = in_year + 14'd1;

	// leap flags for the three years a result can land in
	cdu_leap u_leap_cur  (.year(in_year), .cent(cent_cur),  .leap(leap_cur));
	cdu_leap u_leap_prev (.year(y_prev),  .cent(cent_prev), .leap(leap_prev));
	cdu_leap u_leap_next (.year(y_next),  .cent(cent_next), .leap(leap_next));

	assign mi         = in_month[3:0];
	assign di         = in_day[4:0];
	assign dim_cur    = month_days(mi, leap_cur);
	assign dim_before = month_days(mi - 4'd1, leap_cur);

	assign valid = (in_month >= 7'd1) && (in_month <= 7'd12)
		&& (in_year >= 14'd1) && (in_year <= 14'(MAX_YEAR))
		&& (in_day != 7'd0) && (in_day <= {2'd0, dim_cur});

	// whole years before this one: 365p + p/4 - p/100 + p/400
	assign n_years = 22'({8'd0, y_prev} * {13'd0, DAYS_IN_YEAR})
		+ {10'd0, y_prev[13:2]} - {14'd0, cent_prev} + {16'd0, cent_prev[7:2]};
	assign n_days  = n_years + {13'd0, days_before(mi)}
		+ {21'd0, leap_cur && (mi > 4'd2)} + {17'd0, di};

	always_comb begin
		res.day   = di;
		res.month = mi;
		res.year  = in_year;
		res.ok    = 1'b1;
		res.leap  = leap_cur;
		res.num   = 22'd0;
		case (action)
			ACT_NEXT: begin
				if (di < dim_cur) begin
					res.day = di + 5'd1;
				end else if (mi < 4'd12) begin
					res.day   = 5'd1;
					res.month = mi + 4'd1;
				end else if (in_year < 14'(MAX_YEAR)) begin
					res.day   = 5'd1;
					res.month = 4'd1;
					res.year  = y_next;
					res.leap  = leap_next;
				end else begin
					res.ok = 1'b0;
				end
			end
			ACT_PREV: begin
				if (di > 5'd1) begin
					res.day = di - 5'd1;
				end else if (mi > 4'd1) begin
					res.month = mi - 4'd1;
					res.day   = dim_before;
				end else if (in_year > 14'd1) begin
					res.day   = 5'd31;
					res.month = 4'd12;
					res.year  = y_prev;
					res.leap  = leap_prev;
				end else begin
					res.ok = 1'b0;
				end
			end
			ACT_DAYNUM: begin
				res.num = n_days;
			end
			default: begin
			end
		endcase
		if (!valid) begin
			res = '0;
		end
	end

endmodule

>>> rtl/calendar_date_unit_top.sv
`timescale 1ns / 1ps

// channel  dir  fields
// -------  ---  ---------------------------------------------------------
// req      in   action, in_day, in_month, in_year
// rsp      out  out_day, out_month, out_year, date_ok, leap_year, day_number
//
// one item per cycle sustained while rsp is ready; each item goes from accept
// to result through input register, single pass of date logic, result register
// arst_n clears both stage valid flags; payload registers are not reset
// a stalled rsp holds the result register, and req keeps accepting while
// the input register is empty or moving into the result register

module calendar_date_unit_top
	import cdu_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	cdu_req_if.sink req,
	cdu_rsp_if.source rsp
);

	// input stage
	logic        v_s1;
	logic [1:0]  action_s1;
	logic [6:0]  day_s1;
	logic [6:0]  month_s1;
	logic [13:0] year_s1;

	// result stage
	logic        v_s2;
	cdu_result_t res_s2;

	cdu_result_t res;
	logic        adv;

	// result register can take a new item when empty or being drained
	assign adv       = !v_s2 || rsp.ready;
	assign req.ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (req.ready) begin
				v_s1 <= req.valid;
			end
			if (adv) begin
				v_s2 <= v_s1;
			end
		end
	end

	// capture the request item
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			action_s1 <= req.action;
			day_s1    <= req.in_day;
			month_s1  <= req.in_month;
			year_s1   <= req.in_year;
		end
	end

	// all date arithmetic in one pass
	cdu_core u_core (
		.action  (action_s1),
		.in_day  (day_s1),
		.in_month(month_s1),
		.in_year (year_s1),
		.res     (res)
	);

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			res_s2 <= res;
		end
	end

	assign rsp.valid      = v_s2;
	assign rsp.out_day    = res_s2.day;
	assign rsp.out_month  = res_s2.month;
	assign rsp.out_year   = res_s2.year;
	assign rsp.date_ok    = res_s2.ok;
	assign rsp.leap_year  = res_s2.leap;
	assign rsp.day_number = res_s2.num;

`ifndef NO_ASSERTIONS
	// an invalid date comes out all zero
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.date_ok && rsp.out_month == 4'd0)
		|-> (rsp.out_day == 5'd0 && rsp.out_year == 14'd0 && !rsp.leap_year))
		else $error("invalid date result not cleared");

	// a day number is only given for a valid date
	a_num_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.day_number != 22'd0) |-> rsp.date_ok)
		else $error("day number with date_ok low");

	// a good result is a real calendar date
	a_ok_range: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.date_ok) |-> (rsp.out_month >= 4'd1 && rsp.out_month <= 4'd12
		&& rsp.out_day >= 5'd1 && rsp.out_year >= 14'd1))
		else $error("date_ok with out-of-range date");

	// a held input item is not dropped during a stall
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !adv) |=> v_s1)
		else $error("input stage lost an item");

	// an empty input stage always takes a request
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> req.ready)
		else $error("ready low with empty input stage");
`endif

endmodule
